/* rtl/dfr_pkg.sv */
`default_nettype none
package dfr_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_HDR_FIRST  = 3'd0,
    REG_HDR_SECOND = 3'd1,
    REG_MAX_LEN    = 3'd2,
    REG_READ_CODE  = 3'd3,
    REG_WRITE_CODE = 3'd4,
    REG_ACK_FIRST  = 3'd5,
    REG_ACK_SECOND = 3'd6,
    REG_IGN_ADDR   = 3'd7
  } reg_idx_t;

  localparam logic [7:0]  RstHdrFirst  = 8'h5A;
  localparam logic [7:0]  RstHdrSecond = 8'hA5;
  localparam logic [7:0]  RstMaxLen    = 8'd249;
  localparam logic [7:0]  RstReadCode  = 8'h83;
  localparam logic [7:0]  RstWriteCode = 8'h82;
  localparam logic [7:0]  RstAckFirst  = 8'h4F;
  localparam logic [7:0]  RstAckSecond = 8'h4B;
  localparam logic [15:0] RstIgnAddr   = 16'h3000;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_LEN   = 3'b010,
    PH_FRAME = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    VERD_OK        = 3'd0,
    VERD_WRONG_SZ  = 3'd1,
    VERD_IGNORED   = 3'd2,
    VERD_UNKNOWN   = 3'd3,
    VERD_TOO_SHORT = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    logic [7:0]  max_len;
    logic [7:0]  read_code;
    logic [7:0]  write_code;
    logic [7:0]  ack_first;
    logic [7:0]  ack_second;
    logic [15:0] ign_addr;
  } cfg_t;

  typedef struct packed {
    logic        has_result;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] address;
    kind_t       frame_kind;
    logic [7:0]  byte_offset;
    logic        frame_end;
    verdict_t    verdict;
  } result_t;

endpackage
`default_nettype wire

/* rtl/display_frame_receiver.sv */
// an accepted byte passes through the input register and then the result register
// throughput: one byte per cycle; the input register and the result register
// take a new transfer in every cycle while out_ready is high
// reset: synchronous active-high rst clears the parser to header hunt, empties
// both registers and loads the configuration registers with their defaults
`default_nettype none
module display_frame_receiver
  import dfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       rx_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            payload_byte,
  output logic                  payload_valid,
  output logic [15:0]           address,
  output logic [1:0]            frame_kind,
  output logic [7:0]            byte_offset,
  output logic                  frame_end,
  output logic [2:0]            verdict
);

  cfg_t       cfg;
  result_t    res;
  logic       byte_vld;
  logic [7:0] byte_q;
  logic       out_free, step;

  assign pready   = 1'b1;
  assign out_free = !out_valid || out_ready;
  assign step     = byte_vld && out_free;
  assign in_ready = !byte_vld || step;

  dfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dfr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .b    (byte_q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (in_ready) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result fields load only when a byte leaves the input register
  always_ff @(posedge clk) begin
    if (step) begin
      payload_byte  <= res.payload_byte;
      payload_valid <= res.payload_valid;
      address       <= res.address;
      frame_kind    <= res.frame_kind;
      byte_offset   <= res.byte_offset;
      frame_end     <= res.frame_end;
      verdict       <= res.verdict;
    end
  end

endmodule
`default_nettype wire

/* rtl/dfr_cfg.sv */
`default_nettype none
module dfr_cfg
  import dfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hdr_first  <= RstHdrFirst;
      cfg.hdr_second <= RstHdrSecond;
      cfg.max_len    <= RstMaxLen;
      cfg.read_code  <= RstReadCode;
      cfg.write_code <= RstWriteCode;
      cfg.ack_first  <= RstAckFirst;
      cfg.ack_second <= RstAckSecond;
      cfg.ign_addr   <= RstIgnAddr;
    end else if (wr_en) begin
      unique case (idx)
        REG_HDR_FIRST:  cfg.hdr_first  <= pwdata[7:0];
        REG_HDR_SECOND: cfg.hdr_second <= pwdata[7:0];
        REG_MAX_LEN:    cfg.max_len    <= pwdata[7:0];
        REG_READ_CODE:  cfg.read_code  <= pwdata[7:0];
        REG_WRITE_CODE: cfg.write_code <= pwdata[7:0];
        REG_ACK_FIRST:  cfg.ack_first  <= pwdata[7:0];
        REG_ACK_SECOND: cfg.ack_second <= pwdata[7:0];
        REG_IGN_ADDR:   cfg.ign_addr   <= pwdata[15:0];
        default:        cfg.ign_addr   <= cfg.ign_addr;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HDR_FIRST:  prdata = {24'd0, cfg.hdr_first};
      REG_HDR_SECOND: prdata = {24'd0, cfg.hdr_second};
      REG_MAX_LEN:    prdata = {24'd0, cfg.max_len};
      REG_READ_CODE:  prdata = {24'd0, cfg.read_code};
      REG_WRITE_CODE: prdata = {24'd0, cfg.write_code};
      REG_ACK_FIRST:  prdata = {24'd0, cfg.ack_first};
      REG_ACK_SECOND: prdata = {24'd0, cfg.ack_second};
      REG_IGN_ADDR:   prdata = {16'd0, cfg.ign_addr};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/dfr_core.sv */
`default_nettype none
module dfr_core
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] b,
  input  wire cfg_t       cfg,
  output result_t         res
);

  phase_t      phase, phase_next;
  logic        prior_hf, prior_hf_next;
  logic [7:0]  bif;
  logic [7:0]  frame_len;
  logic [7:0]  instr;
  logic [15:0] faddr;
  logic [7:0]  wcount;
  logic        ack_match;

  logic [7:0]  instr_eff, wc_eff, off, bif_inc;
  logic [15:0] addr_eff;
  logic        ack_eff, is_read, is_write, pv, at_end, bad_len, len_load;
  kind_t       kind;
  verdict_t    verd;

  // frame body fields as they stand after this byte
  always_comb begin
    instr_eff = (bif == 8'd0) ? b : instr;
    addr_eff  = faddr;
    ack_eff   = ack_match;
    wc_eff    = (bif == 8'd3) ? b : wcount;
    if (bif == 8'd1) begin
      addr_eff = {b, 8'd0};
    end else if (bif == 8'd2) begin
      addr_eff = {faddr[15:8], b};
      ack_eff  = (faddr[15:8] == cfg.ack_first) && (b == cfg.ack_second);
    end
  end

  assign is_read  = (instr_eff == cfg.read_code);
  assign is_write = !is_read && (instr_eff == cfg.write_code);
  assign bif_inc  = bif + 8'd1;
  assign at_end   = (bif_inc == frame_len);
  assign bad_len  = (b == 8'd0) || (b > cfg.max_len);

  always_comb begin
    pv  = 1'b0;
    off = 8'd0;
    if (is_read && bif >= 8'd4) begin
      pv  = 1'b1;
      off = bif - 8'd4;
    end else if (is_write && bif >= 8'd3) begin
      pv  = 1'b1;
      off = bif - 8'd3;
    end
  end

  always_comb begin
    kind = is_read ? KIND_READ : (is_write ? KIND_WRITE : KIND_OTHER);
    verd = VERD_OK;
    if (at_end) begin
      if (is_read) begin
        if (frame_len < 8'd4) begin
          verd = VERD_TOO_SHORT;
        end else if ({2'b00, frame_len} != (10'd4 + {1'b0, wc_eff, 1'b0})) begin
          verd = VERD_WRONG_SZ;
        end else if (addr_eff == cfg.ign_addr) begin
          verd = VERD_IGNORED;
        end
      end else if (is_write) begin
        if (frame_len == 8'd3 && ack_eff) begin
          kind = KIND_ACK;
        end else if (frame_len < 8'd4) begin
          verd = VERD_TOO_SHORT;
        end
      end else begin
        verd = VERD_UNKNOWN;
      end
    end
  end

  always_comb begin
    phase_next    = phase;
    prior_hf_next = prior_hf;
    len_load      = 1'b0;
    unique case (phase)
      PH_LEN: begin
        if (bad_len) begin
          // drop the header's first byte and rescan what is held
          if (cfg.hdr_second == cfg.hdr_first && b == cfg.hdr_second) begin
            prior_hf_next = 1'b0;
          end else begin
            phase_next    = PH_HUNT;
            prior_hf_next = (b == cfg.hdr_first);
          end
        end else begin
          phase_next = PH_FRAME;
          len_load   = 1'b1;
        end
      end
      PH_FRAME: begin
        if (at_end) begin
          phase_next    = PH_HUNT;
          prior_hf_next = 1'b0;
        end
      end
      default: begin
        if (prior_hf && b == cfg.hdr_second) begin
          phase_next    = PH_LEN;
          prior_hf_next = 1'b0;
        end else begin
          phase_next    = PH_HUNT;
          prior_hf_next = (b == cfg.hdr_first);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      prior_hf  <= 1'b0;
      bif       <= 8'd0;
      frame_len <= 8'd0;
      instr     <= 8'd0;
      faddr     <= 16'd0;
      wcount    <= 8'd0;
      ack_match <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      prior_hf <= prior_hf_next;
      if (len_load) begin
        frame_len <= b;
        bif       <= 8'd0;
        instr     <= 8'd0;
        faddr     <= 16'd0;
        wcount    <= 8'd0;
        ack_match <= 1'b0;
      end else if (phase == PH_FRAME) begin
        bif       <= bif_inc;
        instr     <= instr_eff;
        faddr     <= addr_eff;
        wcount    <= wc_eff;
        ack_match <= ack_eff;
      end
    end
  end

  always_comb begin
    res.has_result    = (phase == PH_FRAME) && (pv || at_end);
    res.payload_byte  = pv ? b : 8'd0;
    res.payload_valid = pv;
    res.address       = addr_eff;
    res.frame_kind    = kind;
    res.byte_offset   = off;
    res.frame_end     = at_end;
    res.verdict       = verd;
  end

endmodule
`default_nettype wire

/* rtl/dfr_checker.sv */
`default_nettype none
module dfr_checker
  import dfr_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [7:0]       payload_byte,
  input wire logic             payload_valid,
  input wire logic [15:0]      address,
  input wire logic [7:0]       byte_offset,
  input wire logic             frame_end,
  input wire logic [2:0]       verdict
);

  // nothing is offered right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // every result is a data byte or closes a frame
  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (payload_valid || frame_end))
    else $error("result with neither data nor frame end");

  // non-data results carry zeroed data fields
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !payload_valid) |-> (payload_byte == 8'd0 && byte_offset == 8'd0))
    else $error("data fields set on a result without data");

  // a verdict only appears at the end of a frame
  a_verdict_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (verdict == VERD_OK))
    else $error("verdict set before frame end");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(payload_byte) && $stable(address)
      && $stable(verdict) && $stable(frame_end)))
    else $error("stalled result changed");

endmodule

bind display_frame_receiver dfr_checker u_dfr_checker (.*);
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import dfr_pkg::*;

  localparam int CycleLimit = 600000;

  // opening frames at the reset settings: zero length, over-long length,
  // write acknowledge, read reply at the ignored address, unknown instruction
  localparam logic [7:0] OpeningBytes [25] = '{
    RstHdrFirst, RstHdrSecond, 8'd0,
    RstHdrFirst, RstHdrSecond, 8'hFF,
    RstHdrFirst, RstHdrSecond, 8'd3, RstWriteCode, RstAckFirst, RstAckSecond,
    RstHdrFirst, RstHdrSecond, 8'd6, RstReadCode, RstIgnAddr[15:8], RstIgnAddr[7:0],
    8'd1, 8'h11, 8'h22,
    RstHdrFirst, RstHdrSecond, 8'd1, 8'h00
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       payload_byte;
  logic             payload_valid;
  logic [15:0]      address;
  logic [1:0]       frame_kind;
  logic [7:0]       byte_offset;
  logic             frame_end;
  logic [2:0]       verdict;

  display_frame_receiver DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .payload_byte(payload_byte), .payload_valid(payload_valid),
    .address(address), .frame_kind(frame_kind), .byte_offset(byte_offset),
    .frame_end(frame_end), .verdict(verdict)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser copy and its settings
  cfg_t        cfg_q = '{RstHdrFirst, RstHdrSecond, RstMaxLen, RstReadCode,
                         RstWriteCode, RstAckFirst, RstAckSecond, RstIgnAddr};
  phase_t      parse_phase = PH_HUNT;
  logic        saw_hdr_first = 1'b0;
  logic [7:0]  body_count = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  frame_instr = '0;
  logic [15:0] frame_addr = '0;
  logic [7:0]  word_count = '0;
  logic        ack_seen = 1'b0;

  result_t     pending_results [$];
  logic [7:0]  rx_backlog [$];

  int mismatches = 0;
  int results_checked = 0;
  int frames_closed = 0;
  int payload_seen = 0;
  int bytes_sent = 0;
  int bytes_queued = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [15:0] stall_mask = '1;
  int mask_age = 0;

  task automatic track_rx_byte(input logic [7:0] b);
    result_t  res;
    logic     is_rd, is_wr, pv, last;
    logic [7:0] idx, off;
    kind_t    kind;
    verdict_t verd;
    res = '0;
    pv = 1'b0;
    off = '0;
    verd = VERD_OK;
    case (parse_phase)
      PH_LEN: begin
        if (b == 8'd0 || b > cfg_q.max_len) begin
          // equal header bytes: a bad length that repeats them is a new header
          if (cfg_q.hdr_second == cfg_q.hdr_first && b == cfg_q.hdr_second) begin
            saw_hdr_first = 1'b0;
          end else begin
            parse_phase = PH_HUNT;
            saw_hdr_first = (b == cfg_q.hdr_first);
          end
        end else begin
          parse_phase = PH_FRAME;
          frame_len = b;
          body_count = '0;
          frame_instr = '0;
          frame_addr = '0;
          word_count = '0;
          ack_seen = 1'b0;
        end
      end
      PH_FRAME: begin
        idx = body_count;
        if (idx == 8'd0) begin
          frame_instr = b;
        end else if (idx == 8'd1) begin
          frame_addr = {b, 8'h00};
        end else if (idx == 8'd2) begin
          frame_addr[7:0] = b;
          ack_seen = (frame_addr[15:8] == cfg_q.ack_first) && (b == cfg_q.ack_second);
        end else if (idx == 8'd3) begin
          word_count = b;
        end
        is_rd = (frame_instr == cfg_q.read_code);
        is_wr = !is_rd && (frame_instr == cfg_q.write_code);
        kind = is_rd ? KIND_READ : (is_wr ? KIND_WRITE : KIND_OTHER);
        if (is_rd && idx >= 8'd4) begin
          pv = 1'b1;
          off = idx - 8'd4;
        end else if (is_wr && idx >= 8'd3) begin
          pv = 1'b1;
          off = idx - 8'd3;
        end
        body_count = idx + 8'd1;
        last = (body_count == frame_len);
        if (last) begin
          if (is_rd) begin
            if (frame_len < 8'd4) verd = VERD_TOO_SHORT;
            else if (int'(frame_len) != 4 + 2 * int'(word_count)) verd = VERD_WRONG_SZ;
            else if (frame_addr == cfg_q.ign_addr) verd = VERD_IGNORED;
          end else if (is_wr) begin
            if (frame_len == 8'd3 && ack_seen) kind = KIND_ACK;
            else if (frame_len < 8'd4) verd = VERD_TOO_SHORT;
          end else begin
            verd = VERD_UNKNOWN;
          end
          parse_phase = PH_HUNT;
          saw_hdr_first = 1'b0;
          frames_closed++;
        end
        if (pv || last) begin
          res.payload_byte = pv ? b : 8'd0;
          res.payload_valid = pv;
          res.address = frame_addr;
          res.frame_kind = kind;
          res.byte_offset = off;
          res.frame_end = last;
          res.verdict = verd;
          pending_results.push_back(res);
        end
      end
      default: begin
        parse_phase = PH_HUNT;
        if (saw_hdr_first && b == cfg_q.hdr_second) begin
          parse_phase = PH_LEN;
          saw_hdr_first = 1'b0;
        end else begin
          saw_hdr_first = (b == cfg_q.hdr_first);
        end
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endtask

  // one frame, mostly well formed, built against the current settings
  task automatic queue_frame();
    int sel, flen, wc, ml;
    logic [7:0]  code;
    logic [15:0] addr;
    ml = int'(cfg_q.max_len);
    sel = $urandom_range(0, 99);
    if (sel >= 95) begin
      repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
      return;
    end
    if ($urandom_range(0, 7) == 0) queue_byte(cfg_q.hdr_first);
    queue_byte(cfg_q.hdr_first);
    queue_byte(cfg_q.hdr_second);
    if (sel < 8) begin
      case ($urandom_range(0, 2))
        0: queue_byte(8'd0);
        1: queue_byte(ml == 255 ? 8'd0 : 8'($urandom_range(ml + 1, 255)));
        default: queue_byte(cfg_q.hdr_first);
      endcase
      return;
    end
    addr = 16'($urandom);
    wc = 0;
    if (sel < 40) begin
      code = cfg_q.read_code;
      wc = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 4);
      while (wc > 0 && 4 + 2 * wc > ml) wc--;
      flen = 4 + 2 * wc;
      if (flen > ml || $urandom_range(0, 9) == 0) flen = $urandom_range(1, ml);
      if ($urandom_range(0, 5) == 0) addr = cfg_q.ign_addr;
    end else if (sel < 75) begin
      code = cfg_q.write_code;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          flen = 3;
          addr = {cfg_q.ack_first, cfg_q.ack_second};
        end
        4, 5, 6: flen = $urandom_range(1, 3);
        7: flen = $urandom_range(4, 255);
        default: flen = $urandom_range(4, 12);
      endcase
      if (flen > ml) flen = $urandom_range(1, ml);
    end else begin
      do code = 8'($urandom); while (code == cfg_q.read_code || code == cfg_q.write_code);
      flen = $urandom_range(1, ml < 8 ? ml : 8);
    end
    queue_byte(8'(flen));
    for (int k = 0; k < flen; k++) begin
      case (k)
        0: queue_byte(code);
        1: queue_byte(addr[15:8]);
        2: queue_byte(addr[7:0]);
        3: queue_byte(code == cfg_q.read_code ? 8'(wc) : 8'($urandom));
        default: queue_byte(8'($urandom));
      endcase
    end
  endtask

  // sender pause: nothing queued, nothing in flight, every result back
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HDR_FIRST:  cfg_q.hdr_first = val[7:0];
      REG_HDR_SECOND: cfg_q.hdr_second = val[7:0];
      REG_MAX_LEN:    cfg_q.max_len = val[7:0];
      REG_READ_CODE:  cfg_q.read_code = val[7:0];
      REG_WRITE_CODE: cfg_q.write_code = val[7:0];
      REG_ACK_FIRST:  cfg_q.ack_first = val[7:0];
      REG_ACK_SECOND: cfg_q.ack_second = val[7:0];
      default:        cfg_q.ign_addr = val;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] hf, input logic [7:0] hs,
                              input logic [7:0] ml, input logic [7:0] rc,
                              input logic [7:0] wc, input logic [7:0] af,
                              input logic [7:0] as2, input logic [15:0] ia);
    write_reg(REG_HDR_FIRST, 16'(hf));
    write_reg(REG_HDR_SECOND, 16'(hs));
    write_reg(REG_MAX_LEN, 16'(ml));
    write_reg(REG_READ_CODE, 16'(rc));
    write_reg(REG_WRITE_CODE, 16'(wc));
    write_reg(REG_ACK_FIRST, 16'(af));
    write_reg(REG_ACK_SECOND, 16'(as2));
    write_reg(REG_IGN_ADDR, ia);
    settings_used++;
  endtask

  task automatic run_frames(input int n_bytes);
    bytes_queued = 0;
    while (bytes_queued < n_bytes) queue_frame();
    wait_drained();
  endtask

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_rx_byte(rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte <= rx_backlog.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready follows a rotating mask that is redrawn now and then
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_mask <= '1;
      mask_age <= 0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: transfer with no result pending, payload_byte 0x%0h frame_end %0b",
                   $time, payload_byte, frame_end);
          mismatches++;
        end else begin
          result_t want;
          want = pending_results.pop_front();
          check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
          check_field("payload_valid", 16'(want.payload_valid), 16'(payload_valid));
          check_field("address", want.address, address);
          check_field("frame_kind", 16'(want.frame_kind), 16'(frame_kind));
          check_field("byte_offset", 16'(want.byte_offset), 16'(byte_offset));
          check_field("frame_end", 16'(want.frame_end), 16'(frame_end));
          check_field("verdict", 16'(want.verdict), 16'(verdict));
          results_checked++;
          if (want.payload_valid) payload_seen++;
        end
      end
      if (mask_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask <= '1;
          1: stall_mask <= 16'($urandom) | 16'h0001;
          2: stall_mask <= (16'h0001 << $urandom_range(0, 15)) | 16'h0001;
          default: stall_mask <= 16'($urandom) | 16'h8001;
        endcase
        mask_age <= $urandom_range(50, 300);
      end else begin
        stall_mask <= {stall_mask[14:0], stall_mask[15]};
        mask_age <= mask_age - 1;
      end
      out_ready <= stall_mask[15];
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [7:0] hf, rc;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (OpeningBytes[k]) queue_byte(OpeningBytes[k]);
    run_frames(200);

    // narrowest settings: equal header bytes, one-byte frames, shared code
    program_regs(8'h00, 8'h00, 8'd1, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0000);
    run_frames(150);

    program_regs(8'hFF, 8'h00, 8'd255, 8'h00, 8'h01, 8'hFF, 8'hFF, 16'hFFFF);
    run_frames(250);

    program_regs(RstHdrFirst, RstHdrFirst, 8'd8, RstReadCode, RstReadCode,
                 RstAckFirst, RstAckSecond, RstIgnAddr);
    run_frames(200);

    repeat (3) begin
      hf = 8'($urandom);
      rc = 8'($urandom);
      program_regs(hf,
                   ($urandom_range(0, 3) == 0) ? hf : 8'($urandom),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 10))
                                               : 8'($urandom_range(1, 255)),
                   rc,
                   ($urandom_range(0, 4) == 0) ? rc : 8'($urandom),
                   8'($urandom), 8'($urandom), 16'($urandom));
      run_frames(200);
    end

    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    $display("run: %0d bytes sent under %0d register settings, %0d results checked",
             bytes_sent, settings_used, results_checked);
    $display("run: %0d frames closed, %0d payload bytes, %0d mismatches",
             frames_closed, payload_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dfr_pkg.sv
rtl/dfr_cfg.sv
rtl/dfr_core.sv
rtl/display_frame_receiver.sv
rtl/dfr_checker.sv
bench/testbench.sv
